@@ hw/rtl/owr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owr_pkg
// Shared constants, codes and helpers for the orthogonal wire router.
// ----------------------------------------------------------------------------
package owr_pkg;

  localparam int CLEARANCE   = 8;
  localparam int EDGE_MARGIN = 6;
  localparam int ROUTE_SLOTS = 6;
  localparam int BOX_BITS    = 11;
  localparam int CANVAS_BITS = 11;
  localparam int COUNT_BITS  = 5;

  // opcodes
  localparam logic [1:0] OP_NODE  = 2'd0;
  localparam logic [1:0] OP_PORT  = 2'd1;
  localparam logic [1:0] OP_ROUTE = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_CANVAS_W = 2'd0;
  localparam logic [1:0] CFG_CANVAS_H = 2'd1;
  localparam logic [1:0] CFG_NODE_CNT = 2'd2;

  // status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_BAD_REQ  = 3'd1;
  localparam logic [2:0] STS_NO_CORR  = 3'd2;
  localparam logic [2:0] STS_TOO_MANY = 3'd3;
  localparam logic [2:0] STS_CROSSES  = 3'd4;

  // result control group from the core to the output register
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [2:0] number;
    logic [2:0] status;
  } res_ctl_t;

  // lane mod 5 via reciprocal multiply, exact for 8-bit lanes
  function automatic logic [2:0] lane_mod5(input logic [7:0] lane);
    logic [17:0] prod;
    logic [7:0]  quo;
    logic [10:0] back;
    prod = 18'(lane) * 18'd205;
    quo  = prod[17:10];
    back = 11'(quo) * 11'd5;
    return 3'(11'(lane) - back);
  endfunction

  // corridor offset picked by lane mod 5
  function automatic logic signed [4:0] lane_shift(input logic [2:0] m);
    logic signed [4:0] s;
    case (m)
      3'd0:    s = 5'sd0;
      3'd1:    s = -5'sd5;
      3'd2:    s = 5'sd5;
      3'd3:    s = -5'sd10;
      3'd4:    s = 5'sd10;
      default: s = 5'sd0;
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/owr_tables.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owr_tables
// Node rectangle and port position memories, one port each, registered read.
// ----------------------------------------------------------------------------
module owr_tables import owr_pkg::*; #(
  parameter int MAX_NODES      = 16,
  parameter int PORTS_PER_NODE = 4,
  parameter int COORD_BITS     = 12,
  localparam int NAW = $clog2(MAX_NODES),
  localparam int PAW = $clog2(MAX_NODES * PORTS_PER_NODE),
  localparam int NRW = 2 * COORD_BITS + 2 * BOX_BITS,
  localparam int PRW = 2 * COORD_BITS
) (
  input  logic           clk_i,
  input  logic           node_we_i,
  input  logic [NAW-1:0] node_addr_i,
  input  logic [NRW-1:0] node_wdata_i,
  output logic [NRW-1:0] node_rdata_o,
  input  logic           port_we_i,
  input  logic [PAW-1:0] port_addr_i,
  input  logic [PRW-1:0] port_wdata_i,
  output logic [PRW-1:0] port_rdata_o
);

  logic [NRW-1:0] node_mem [MAX_NODES];
  logic [PRW-1:0] port_mem [MAX_NODES * PORTS_PER_NODE];

  always_ff @(posedge clk_i) begin
    if (node_we_i) begin
      node_mem[node_addr_i] <= node_wdata_i;
    end
    node_rdata_o <= node_mem[node_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (port_we_i) begin
      port_mem[port_addr_i] <= port_wdata_i;
    end
    port_rdata_o <= port_mem[port_addr_i];
  end

endmodule

@@ hw/rtl/owr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owr_core
// Route sequencer: table loads, node scans, spine and bus pick, point
// build, segment check against every active node, and result emission.
// ----------------------------------------------------------------------------
module owr_core import owr_pkg::*; #(
  parameter int MAX_NODES      = 16,
  parameter int PORTS_PER_NODE = 4,
  parameter int MAX_POINTS     = 8,
  parameter int COORD_BITS     = 12,
  localparam int NAW = $clog2(MAX_NODES),
  localparam int PAW = $clog2(MAX_NODES * PORTS_PER_NODE),
  localparam int NRW = 2 * COORD_BITS + 2 * BOX_BITS,
  localparam int PRW = 2 * COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   opcode_i,
  input  logic [3:0]                   node_index_i,
  input  logic [1:0]                   port_index_i,
  input  logic [3:0]                   second_node_i,
  input  logic [1:0]                   second_port_i,
  input  logic [7:0]                   lane_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic [BOX_BITS-1:0]          box_width_i,
  input  logic [BOX_BITS-1:0]          box_height_i,
  input  logic [CANVAS_BITS-1:0]       canvas_width_i,
  input  logic [CANVAS_BITS-1:0]       canvas_height_i,
  input  logic [COUNT_BITS-1:0]        node_count_i,
  output logic                         node_we_o,
  output logic [NAW-1:0]               node_addr_o,
  output logic [NRW-1:0]               node_wdata_o,
  input  logic [NRW-1:0]               node_rdata_i,
  output logic                         port_we_o,
  output logic [PAW-1:0]               port_addr_o,
  output logic [PRW-1:0]               port_wdata_o,
  input  logic [PRW-1:0]               port_rdata_i,
  output logic                         busy_o,
  output res_ctl_t                     res_o,
  output logic [COORD_BITS-1:0]        res_x_o,
  output logic [COORD_BITS-1:0]        res_y_o
);

  // internal coordinate width: holds right/bottom edges plus margins
  localparam int IW    = ((COORD_BITS > 12) ? COORD_BITS : 12) + 4;
  localparam int CNTW  = $clog2(MAX_NODES + 1);
  localparam int LIMIT = (MAX_POINTS < ROUTE_SLOTS) ? MAX_POINTS : ROUTE_SLOTS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LD1    = 4'd1;
  localparam logic [3:0] S_LD2    = 4'd2;
  localparam logic [3:0] S_LD3    = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SP1    = 4'd5;
  localparam logic [3:0] S_SP2    = 4'd6;
  localparam logic [3:0] S_BUS1   = 4'd7;
  localparam logic [3:0] S_BUS2   = 4'd8;
  localparam logic [3:0] S_BUILD  = 4'd9;
  localparam logic [3:0] S_CHK0   = 4'd10;
  localparam logic [3:0] S_CHKSEG = 4'd11;
  localparam logic [3:0] S_CHKSCN = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;
  localparam logic [3:0] S_FAIL   = 4'd14;

  typedef logic signed [IW-1:0] crd_t;

  logic [3:0] state_q, state_d;
  logic [3:0] n1_q, n1_d, n2_q, n2_d;
  logic [1:0] p1_q, p1_d, p2_q, p2_d;
  logic [7:0] lane_q, lane_d;
  logic [2:0] mod5_q, mod5_d;
  logic [2:0] fail_q, fail_d;
  logic       left1_q, left1_d, left2_q, left2_d;
  crd_t x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  crd_t nl1_q, nl1_d, nr1_q, nr1_d;
  crd_t lo1_q, lo1_d, hi1_q, hi1_d, lo2_q, lo2_d, hi2_q, hi2_d;
  crd_t top_q, top_d, bot_q, bot_d;
  crd_t s1_q, s1_d, s2_q, s2_d;
  crd_t tr_q, tr_d, br_q, br_d, ry_q, ry_d;
  crd_t lx_q, lx_d, ly_q, ly_d;
  crd_t ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  crd_t px_q [ROUTE_SLOTS];
  crd_t py_q [ROUTE_SLOTS];
  crd_t px_d [ROUTE_SLOTS];
  crd_t py_d [ROUTE_SLOTS];
  logic [CNTW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [2:0]      cand_q, cand_d, pn_q, pn_d, pi_q, pi_d;

  // active node count
  logic [CNTW-1:0] cnt;
  assign cnt = (32'(node_count_i) > MAX_NODES) ? CNTW'(MAX_NODES) : CNTW'(node_count_i);

  crd_t cw_s, ch_s;
  assign cw_s = IW'($signed({1'b0, canvas_width_i}));
  assign ch_s = IW'($signed({1'b0, canvas_height_i}));

  // node row decode {left, top, width, height}
  crd_t rl, rt, rr, rb, rhw;
  assign rl  = IW'($signed(node_rdata_i[NRW-1 -: COORD_BITS]));
  assign rt  = IW'($signed(node_rdata_i[2*BOX_BITS+COORD_BITS-1 -: COORD_BITS]));
  assign rr  = rl + IW'($signed({1'b0, node_rdata_i[2*BOX_BITS-1 -: BOX_BITS]}));
  assign rb  = rt + IW'($signed({1'b0, node_rdata_i[BOX_BITS-1:0]}));
  assign rhw = IW'($signed({2'b00, node_rdata_i[2*BOX_BITS-1 -: BOX_BITS-1]}));

  crd_t prx, pry;
  assign prx = IW'($signed(port_rdata_i[PRW-1 -: COORD_BITS]));
  assign pry = IW'($signed(port_rdata_i[COORD_BITS-1:0]));

  // shared spine unit: centre of gap (C-style halving), lane offset, clamp
  crd_t sp_lo, sp_hi, sp_sum, sp_half, sp_raw, sp_sel;
  logic sp_empty;
  always_comb begin
    sp_lo   = (state_q == S_SP1) ? lo1_q : lo2_q;
    sp_hi   = (state_q == S_SP1) ? hi1_q : hi2_q;
    sp_sum  = sp_lo + sp_hi;
    sp_half = (sp_sum + ((sp_sum < 0) ? crd_t'(1) : crd_t'(0))) >>> 1;
    sp_raw  = sp_half + IW'(lane_shift(mod5_q));
    sp_empty = sp_lo > sp_hi;
    if (sp_raw < sp_lo) begin
      sp_sel = sp_lo;
    end else if (sp_raw > sp_hi) begin
      sp_sel = sp_hi;
    end else begin
      sp_sel = sp_raw;
    end
  end

  // bus offset and cost compare
  crd_t off, tr_raw, br_raw, ch_lim, d1t, d2t, d1b, d2b, tcost, bcost;
  always_comb begin
    off    = IW'($signed({1'b0, lane_q[1:0], 2'b00})) + IW'(CLEARANCE);
    tr_raw = top_q - off;
    br_raw = bot_q + off;
    ch_lim = ch_s - IW'(EDGE_MARGIN);
    d1t    = y1_q - tr_q;
    d2t    = y2_q - tr_q;
    d1b    = y1_q - br_q;
    d2b    = y2_q - br_q;
    tcost  = ((d1t < 0) ? -d1t : d1t) + ((d2t < 0) ? -d2t : d2t);
    bcost  = ((d1b < 0) ? -d1b : d1b) + ((d2b < 0) ? -d2b : d2b);
  end

  // route candidate point
  crd_t cx, cy;
  logic same_spine;
  logic [2:0] last_cand;
  assign same_spine = (s1_q == s2_q);
  assign last_cand  = same_spine ? 3'd3 : 3'd5;
  always_comb begin
    cx = x2_q;
    cy = y2_q;
    case (cand_q)
      3'd0: begin cx = x1_q; cy = y1_q; end
      3'd1: begin cx = s1_q; cy = y1_q; end
      3'd2: begin
        cx = same_spine ? s2_q : s1_q;
        cy = same_spine ? y2_q : ry_q;
      end
      3'd3: begin
        cx = same_spine ? x2_q : s2_q;
        cy = same_spine ? y2_q : ry_q;
      end
      3'd4: begin cx = s2_q; cy = y2_q; end
      default: begin cx = x2_q; cy = y2_q; end
    endcase
  end

  // segment versus node interior
  logic hit;
  always_comb begin
    if (ay_q == by_q) begin
      hit = (ay_q > rt) && (ay_q < rb) &&
            (((ax_q > bx_q) ? ax_q : bx_q) > rl) && (((ax_q < bx_q) ? ax_q : bx_q) < rr);
    end else begin
      hit = (ax_q > rl) && (ax_q < rr) &&
            (((ay_q > by_q) ? ay_q : by_q) > rt) && (((ay_q < by_q) ? ay_q : by_q) < rb);
    end
  end

  crd_t cur_px, cur_py;
  assign cur_px = px_q[pi_q];
  assign cur_py = py_q[pi_q];

  logic bad_req;
  assign bad_req = (canvas_width_i == '0) || (canvas_height_i == '0) ||
                   (32'(node_index_i) >= 32'(cnt)) || (32'(second_node_i) >= 32'(cnt)) ||
                   (32'(port_index_i) >= PORTS_PER_NODE) ||
                   (32'(second_port_i) >= PORTS_PER_NODE);

  always_comb begin
    state_d = state_q;
    n1_d = n1_q; n2_d = n2_q; p1_d = p1_q; p2_d = p2_q;
    lane_d = lane_q; mod5_d = mod5_q; fail_d = fail_q;
    left1_d = left1_q; left2_d = left2_q;
    x1_d = x1_q; y1_d = y1_q; x2_d = x2_q; y2_d = y2_q;
    nl1_d = nl1_q; nr1_d = nr1_q;
    lo1_d = lo1_q; hi1_d = hi1_q; lo2_d = lo2_q; hi2_d = hi2_q;
    top_d = top_q; bot_d = bot_q; s1_d = s1_q; s2_d = s2_q;
    tr_d = tr_q; br_d = br_q; ry_d = ry_q; lx_d = lx_q; ly_d = ly_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    px_d = px_q; py_d = py_q;
    idx_d = idx_q; pend_d = pend_q;
    cand_d = cand_q; pn_d = pn_q; pi_d = pi_q;

    node_we_o    = 1'b0;
    port_we_o    = 1'b0;
    node_addr_o  = NAW'(node_index_i);
    port_addr_o  = PAW'(32'(node_index_i) * PORTS_PER_NODE + 32'(port_index_i));
    node_wdata_o = {pos_x_i, pos_y_i, box_width_i, box_height_i};
    port_wdata_o = {pos_x_i, pos_y_i};

    res_o   = '0;
    res_x_o = cur_px[COORD_BITS-1:0];
    res_y_o = cur_py[COORD_BITS-1:0];

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (opcode_i)
            OP_NODE: node_we_o = (32'(node_index_i) < MAX_NODES);
            OP_PORT: port_we_o = (32'(node_index_i) < MAX_NODES) &&
                                 (32'(port_index_i) < PORTS_PER_NODE);
            OP_ROUTE: begin
              n1_d = node_index_i; p1_d = port_index_i;
              n2_d = second_node_i; p2_d = second_port_i;
              lane_d = lane_i;
              mod5_d = lane_mod5(lane_i);
              if (bad_req) begin
                fail_d  = STS_BAD_REQ;
                state_d = S_FAIL;
              end else begin
                state_d = S_LD1;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD1: begin
        node_addr_o = NAW'(n1_q);
        port_addr_o = PAW'(32'(n1_q) * PORTS_PER_NODE + 32'(p1_q));
        state_d = S_LD2;
      end
      S_LD2: begin
        x1_d = prx; y1_d = pry;
        nl1_d = rl; nr1_d = rr;
        left1_d = (prx <= rl + rhw);
        node_addr_o = NAW'(n2_q);
        port_addr_o = PAW'(32'(n2_q) * PORTS_PER_NODE + 32'(p2_q));
        state_d = S_LD3;
      end
      S_LD3: begin
        x2_d = prx; y2_d = pry;
        left2_d = (prx <= rl + rhw);
        lo1_d = left1_q ? IW'(EDGE_MARGIN) : nr1_q + IW'(CLEARANCE);
        hi1_d = left1_q ? nl1_q - IW'(CLEARANCE) : cw_s - IW'(EDGE_MARGIN);
        lo2_d = left2_d ? IW'(EDGE_MARGIN) : rr + IW'(CLEARANCE);
        hi2_d = left2_d ? rl - IW'(CLEARANCE) : cw_s - IW'(EDGE_MARGIN);
        // keep the second node's edges in the bus regs' slots for the scan: reuse tr/br
        tr_d = rl; br_d = rr;
        top_d = ch_s; bot_d = '0;
        idx_d = '0; pend_d = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // tr_q/br_q hold node 2 left/right during this scan
        node_addr_o = idx_q[NAW-1:0];
        if (idx_q < cnt) begin
          idx_d  = idx_q + CNTW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (left1_q && (rr <= nl1_q) && (rr + IW'(CLEARANCE) > lo1_q)) begin
            lo1_d = rr + IW'(CLEARANCE);
          end
          if (!left1_q && (rl >= nr1_q) && (rl - IW'(CLEARANCE) < hi1_q)) begin
            hi1_d = rl - IW'(CLEARANCE);
          end
          if (left2_q && (rr <= tr_q) && (rr + IW'(CLEARANCE) > lo2_q)) begin
            lo2_d = rr + IW'(CLEARANCE);
          end
          if (!left2_q && (rl >= br_q) && (rl - IW'(CLEARANCE) < hi2_q)) begin
            hi2_d = rl - IW'(CLEARANCE);
          end
          if (rt < top_q) begin
            top_d = rt;
          end
          if (rb > bot_q) begin
            bot_d = rb;
          end
        end
        if ((idx_q == cnt) && !pend_q) begin
          state_d = S_SP1;
        end
      end
      S_SP1: begin
        s1_d = sp_sel;
        if (sp_empty) begin
          fail_d  = STS_NO_CORR;
          state_d = S_FAIL;
        end else begin
          state_d = S_SP2;
        end
      end
      S_SP2: begin
        s2_d   = sp_sel;
        cand_d = '0;
        pn_d   = '0;
        pi_d   = '0;
        if (sp_empty) begin
          fail_d  = STS_NO_CORR;
          state_d = S_FAIL;
        end else if (sp_sel != s1_q) begin
          state_d = S_BUS1;
        end else begin
          state_d = S_BUILD;
        end
      end
      S_BUS1: begin
        tr_d = (tr_raw < IW'(EDGE_MARGIN)) ? IW'(EDGE_MARGIN) : tr_raw;
        br_d = (br_raw > ch_lim) ? ch_lim : br_raw;
        state_d = S_BUS2;
      end
      S_BUS2: begin
        ry_d = ((tcost < bcost) || ((tcost == bcost) && !lane_q[0])) ? tr_q : br_q;
        state_d = S_BUILD;
      end
      S_BUILD: begin
        if ((pn_q != '0) && (cx == lx_q) && (cy == ly_q)) begin
          // repeated point: dropped
          if (cand_q == last_cand) begin
            state_d = S_CHK0;
          end
          cand_d = cand_q + 3'd1;
        end else if (pn_q >= 3'(LIMIT)) begin
          fail_d  = STS_TOO_MANY;
          state_d = S_FAIL;
        end else begin
          px_d[pn_q] = cx;
          py_d[pn_q] = cy;
          lx_d = cx; ly_d = cy;
          pn_d = pn_q + 3'd1;
          cand_d = cand_q + 3'd1;
          if (cand_q == last_cand) begin
            state_d = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        pi_d = 3'd0;
        if (pn_q < 3'd2) begin
          fail_d  = STS_CROSSES;
          state_d = S_FAIL;
        end else begin
          ax_d = cur_px; ay_d = cur_py;
          pi_d = 3'd1;
          state_d = S_CHKSEG;
        end
      end
      S_CHKSEG: begin
        if ((cur_px != ax_q) && (cur_py != ay_q)) begin
          fail_d  = STS_CROSSES;
          state_d = S_FAIL;
        end else begin
          bx_d = cur_px; by_d = cur_py;
          idx_d = '0; pend_d = 1'b0;
          state_d = S_CHKSCN;
        end
      end
      S_CHKSCN: begin
        node_addr_o = idx_q[NAW-1:0];
        if (idx_q < cnt) begin
          idx_d  = idx_q + CNTW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && hit) begin
          fail_d  = STS_CROSSES;
          state_d = S_FAIL;
        end else if ((idx_q == cnt) && !pend_q) begin
          if (pi_q + 3'd1 < pn_q) begin
            ax_d = bx_q; ay_d = by_q;
            pi_d = pi_q + 3'd1;
            state_d = S_CHKSEG;
          end else begin
            pi_d = 3'd0;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        res_o.valid  = 1'b1;
        res_o.number = pi_q;
        res_o.status = STS_OK;
        res_o.last   = (pi_q + 3'd1 == pn_q);
        pi_d = pi_q + 3'd1;
        if (pi_q + 3'd1 == pn_q) begin
          state_d = S_IDLE;
        end
      end
      S_FAIL: begin
        res_o.valid  = 1'b1;
        res_o.last   = 1'b1;
        res_o.status = fail_q;
        res_x_o = '0;
        res_y_o = '0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      cand_q  <= '0;
      pn_q    <= '0;
      pi_q    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      cand_q  <= cand_d;
      pn_q    <= pn_d;
      pi_q    <= pi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q <= n1_d; n2_q <= n2_d; p1_q <= p1_d; p2_q <= p2_d;
    lane_q <= lane_d; mod5_q <= mod5_d; fail_q <= fail_d;
    left1_q <= left1_d; left2_q <= left2_d;
    x1_q <= x1_d; y1_q <= y1_d; x2_q <= x2_d; y2_q <= y2_d;
    nl1_q <= nl1_d; nr1_q <= nr1_d;
    lo1_q <= lo1_d; hi1_q <= hi1_d; lo2_q <= lo2_d; hi2_q <= hi2_d;
    top_q <= top_d; bot_q <= bot_d; s1_q <= s1_d; s2_q <= s2_d;
    tr_q <= tr_d; br_q <= br_d; ry_q <= ry_d; lx_q <= lx_d; ly_q <= ly_d;
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    px_q <= px_d; py_q <= py_d;
  end

endmodule

@@ hw/rtl/orthogonal_wire_router_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthogonal_wire_router_top
// Node/port tables plus a sequenced router that emits orthogonal wire points.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  command   | start & !busy              | opcode, indexes, lane, pos, box
//  config    | cfg_we_i                   | cfg_index_i, cfg_data_i
//  result    | res_strobe_o (one cycle)   | point x/y, number, last, status
//
//  A route keeps busy high throughout; every scan walks the single-port
//  node memory one row a cycle, and equal spines skip the bus pick.
//  Results leave one per cycle, back to back, from an output register; the
//  receiver cannot stall them. Reset clears control state and sets the
//  registers to 128, 64, 0; table contents are undefined until written.
//
module orthogonal_wire_router_top import owr_pkg::*; #(
  parameter int MAX_NODES      = 16,
  parameter int PORTS_PER_NODE = 4,
  parameter int MAX_POINTS     = 8,
  parameter int COORD_BITS     = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   opcode_i,
  input  logic [3:0]                   node_index_i,
  input  logic [1:0]                   port_index_i,
  input  logic [3:0]                   second_node_i,
  input  logic [1:0]                   second_port_i,
  input  logic [7:0]                   lane_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic [BOX_BITS-1:0]          box_width_i,
  input  logic [BOX_BITS-1:0]          box_height_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [CANVAS_BITS-1:0]       cfg_data_i,
  output logic                         res_strobe_o,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic [2:0]                   point_number_o,
  output logic                         last_point_o,
  output logic [2:0]                   status_o
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int PAW = $clog2(MAX_NODES * PORTS_PER_NODE);
  localparam int NRW = 2 * COORD_BITS + 2 * BOX_BITS;
  localparam int PRW = 2 * COORD_BITS;

  // configuration registers
  logic [CANVAS_BITS-1:0] canvas_w_q, canvas_h_q;
  logic [COUNT_BITS-1:0]  node_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CANVAS_BITS'(128);
      canvas_h_q <= CANVAS_BITS'(64);
      node_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CANVAS_W: canvas_w_q <= cfg_data_i;
        CFG_CANVAS_H: canvas_h_q <= cfg_data_i;
        CFG_NODE_CNT: node_cnt_q <= cfg_data_i[COUNT_BITS-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // table memories
  logic           node_we, port_we;
  logic [NAW-1:0] node_addr;
  logic [PAW-1:0] port_addr;
  logic [NRW-1:0] node_wdata, node_rdata;
  logic [PRW-1:0] port_wdata, port_rdata;

  owr_tables #(
    .MAX_NODES     (MAX_NODES),
    .PORTS_PER_NODE(PORTS_PER_NODE),
    .COORD_BITS    (COORD_BITS)
  ) u_tables (
    .clk_i       (clk_i),
    .node_we_i   (node_we),
    .node_addr_i (node_addr),
    .node_wdata_i(node_wdata),
    .node_rdata_o(node_rdata),
    .port_we_i   (port_we),
    .port_addr_i (port_addr),
    .port_wdata_i(port_wdata),
    .port_rdata_o(port_rdata)
  );

  // route sequencer
  res_ctl_t              res;
  logic [COORD_BITS-1:0] res_x, res_y;

  owr_core #(
    .MAX_NODES     (MAX_NODES),
    .PORTS_PER_NODE(PORTS_PER_NODE),
    .MAX_POINTS    (MAX_POINTS),
    .COORD_BITS    (COORD_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .opcode_i       (opcode_i),
    .node_index_i   (node_index_i),
    .port_index_i   (port_index_i),
    .second_node_i  (second_node_i),
    .second_port_i  (second_port_i),
    .lane_i         (lane_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .box_width_i    (box_width_i),
    .box_height_i   (box_height_i),
    .canvas_width_i (canvas_w_q),
    .canvas_height_i(canvas_h_q),
    .node_count_i   (node_cnt_q),
    .node_we_o      (node_we),
    .node_addr_o    (node_addr),
    .node_wdata_o   (node_wdata),
    .node_rdata_i   (node_rdata),
    .port_we_o      (port_we),
    .port_addr_o    (port_addr),
    .port_wdata_o   (port_wdata),
    .port_rdata_i   (port_rdata),
    .busy_o         (busy),
    .res_o          (res),
    .res_x_o        (res_x),
    .res_y_o        (res_y)
  );

  // result register: each transfer is shown for exactly one cycle
  logic res_strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      point_x_o      <= $signed(res_x);
      point_y_o      <= $signed(res_y);
      point_number_o <= res.number;
      last_point_o   <= res.last;
      status_o       <= res.status;
    end
  end

  assign res_strobe_o = res_strobe_q;

endmodule

@@ hw/rtl/owr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owr_checker
// Port-level checks on the router's command and result behavior.
// ----------------------------------------------------------------------------
module owr_checker import owr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic [1:0]            opcode_i,
  input logic                  res_strobe_o,
  input logic [COORD_BITS-1:0] point_x_o,
  input logic [2:0]            point_number_o,
  input logic                  last_point_o,
  input logic [2:0]            status_o
);

  // a route command always occupies the block
  a_route_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (opcode_i == OP_ROUTE) |=> busy)
    else $error("route command did not raise busy");

  // points of one route follow each other without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_point_o |=> res_strobe_o)
    else $error("gap inside a point burst");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_point_o |=> point_number_o == $past(point_number_o) + 3'd1)
    else $error("point number did not advance");

  // a failure is a single zeroed transfer
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (status_o != STS_OK) |->
      last_point_o && (point_number_o == 3'd0) && (point_x_o == '0))
    else $error("malformed failure transfer");

endmodule

bind orthogonal_wire_router_top owr_checker #(.COORD_BITS(COORD_BITS)) u_owr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .opcode_i      (opcode_i),
  .res_strobe_o  (res_strobe_o),
  .point_x_o     (point_x_o),
  .point_number_o(point_number_o),
  .last_point_o  (last_point_o),
  .status_o      (status_o)
);
